// File: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared widths, status codes, request modes and register indexes.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned STAT_W = 2;

  localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_REJECT = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [IDX_W-1:0] REG_BASE_ADDRESS = 8'd0;
  localparam logic [IDX_W-1:0] REG_BLOCK_COUNT  = 8'd1;

endpackage

// File: rtl/bba_if.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator channels
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bba_req_if
  import bba_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, mode, free_address, input ready);
  modport sink (input valid, mode, free_address, output ready);
endinterface

interface bba_rsp_if
  import bba_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] block_address;
  logic [CNT_W-1:0]  used_count;

  modport source (output valid, status, block_address, used_count, input ready);
  modport sink (input valid, status, block_address, used_count, output ready);
endinterface

interface bba_cfg_if
  import bba_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [ADDR_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bba_div.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator offset divider
// Division of a 32-bit byte offset by the block size. The user must keep the
// block size a power of two; the block does not check it. The quotient is a
// registered right shift, ready in the cycle after start.
// ----------------------------------------------------------------------------
module bba_div
  import bba_pkg::*;
#(
  parameter int unsigned DIVISOR = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  output logic              done,
  output logic [ADDR_W-1:0] quotient
);

  localparam int unsigned SHIFT = $clog2(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
    if (start) begin
      quotient <= dividend >> SHIFT;
    end
  end

endmodule

// File: rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator
// After reset the block clears every word of its bitmap RAM and takes no
// request until that pass is done. An allocate scans the bitmap through the
// read port of the bitmap RAM, one word per cycle, sets the bit of the lowest
// free block, forms its address from the base address and loads the
// response. A free takes the request, forms the block number from the byte
// offset, reads the bitmap word, checks and writes it back, and loads the
// response. BLOCK_BYTES must be a power of two. One request is worked on at
// a time; a finished response may wait in the output register while the
// next request is taken. Register writes are always accepted.
// ----------------------------------------------------------------------------
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS  = 4096,
  parameter int unsigned BLOCK_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst,
  bba_req_if.sink   req,
  bba_rsp_if.source rsp,
  bba_cfg_if.sink   cfg
);

  localparam int unsigned MAP_WORDS = (MAX_BLOCKS + 31) / 32;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW        = AW + 5;
  localparam int unsigned CAP       = (MAX_BLOCKS > 8191) ? 8191 : MAX_BLOCKS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_MUL, S_ADD, S_DIV, S_FREAD, S_FCHECK, S_RESPOND
  } state_t;

  state_t            state;
  logic [AW-1:0]     clr_addr;
  logic [AW:0]       scan_ptr;
  logic [AW:0]       chk_ptr;
  logic              chk_valid;
  logic [BW-1:0]     blk;
  logic [31:0]       hit_data;
  logic [ADDR_W-1:0] prod;
  logic [CNT_W-1:0]  blocks_in_use;
  logic [ADDR_W-1:0] base_address;
  logic [CNT_W-1:0]  block_count;
  logic [STAT_W-1:0] res_status;
  logic [ADDR_W-1:0] res_addr;
  logic              rsp_valid;
  logic [STAT_W-1:0] rsp_status;
  logic [ADDR_W-1:0] rsp_addr;
  logic [CNT_W-1:0]  rsp_count;

  logic [CNT_W-1:0]  managed;
  logic              issue_ok;
  logic [31:0]       lim;
  logic [31:0]       limit_mask;
  logic [31:0]       free_mask;
  logic              hit;
  logic [4:0]        hit_bit;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [31:0]       ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [31:0]       ram_rdata;
  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] div_q;
  logic              req_take;
  logic              bit_set;

  assign managed   = (block_count > CNT_W'(CAP)) ? CNT_W'(CAP) : block_count;
  assign req.ready = (state == S_IDLE);
  assign req_take  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.block_address = rsp_addr;
  assign rsp.used_count    = rsp_count;

  assign issue_ok   = 32'({scan_ptr, 5'b0}) < 32'(managed);
  assign lim        = 32'(managed) - 32'({chk_ptr, 5'b0});
  assign limit_mask = (lim >= 32'd32) ? '1 : ((32'd1 << lim[4:0]) - 32'd1);
  assign free_mask  = ~ram_rdata & limit_mask;
  assign hit        = chk_valid && (free_mask != '0);
  assign bit_set    = ram_rdata[blk[4:0]];

  always_comb begin
    hit_bit = '0;
    for (int i = 31; i >= 0; i--) begin
      if (free_mask[i]) begin
        hit_bit = 5'(i);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = blk[BW-1:5];
    ram_wdata = hit_data | (32'd1 << blk[4:0]);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_MUL: begin
        ram_we = 1'b1;
      end
      S_FCHECK: begin
        ram_we    = bit_set;
        ram_wdata = ram_rdata & ~(32'd1 << blk[4:0]);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_raddr = (state == S_SCAN) ? scan_ptr[AW-1:0] : blk[BW-1:5];

  assign div_start = req_take && (req.mode == MODE_FREE) && (req.free_address >= base_address);

  bba_ram #(
    .WIDTH(32),
    .DEPTH(MAP_WORDS)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bba_div #(
    .DIVISOR(BLOCK_BYTES)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(req.free_address - base_address),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      chk_valid     <= 1'b0;
      blocks_in_use <= '0;
      base_address  <= '0;
      block_count   <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == REG_BASE_ADDRESS) begin
          base_address <= cfg.data;
        end else if (cfg.index == REG_BLOCK_COUNT) begin
          block_count <= cfg.data[CNT_W-1:0];
        end
      end
      if (rsp_valid && rsp.ready && (state != S_RESPOND)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_take) begin
            res_addr   <= '0;
            res_status <= STATUS_OK;
            scan_ptr   <= '0;
            chk_valid  <= 1'b0;
            if (req.mode == MODE_ALLOC) begin
              if (blocks_in_use < managed) begin
                state <= S_SCAN;
              end else begin
                res_status <= STATUS_FULL;
                state      <= S_RESPOND;
              end
            end else if (div_start) begin
              state <= S_DIV;
            end else begin
              res_status <= STATUS_REJECT;
              state      <= S_RESPOND;
            end
          end
        end
        S_SCAN: begin
          chk_valid <= issue_ok;
          chk_ptr   <= scan_ptr;
          if (issue_ok) begin
            scan_ptr <= scan_ptr + 1'b1;
          end
          if (hit) begin
            blk      <= {chk_ptr[AW-1:0], hit_bit};
            hit_data <= ram_rdata;
            state    <= S_MUL;
          end else if (!chk_valid && !issue_ok) begin
            res_status <= STATUS_FULL;
            state      <= S_RESPOND;
          end
        end
        S_MUL: begin
          prod          <= 32'(blk) * 32'(BLOCK_BYTES);
          blocks_in_use <= blocks_in_use + 1'b1;
          state         <= S_ADD;
        end
        S_ADD: begin
          res_addr <= base_address + prod;
          state    <= S_RESPOND;
        end
        S_DIV: begin
          if (div_done) begin
            blk <= div_q[BW-1:0];
            if (div_q >= 32'(managed)) begin
              res_status <= STATUS_REJECT;
              state      <= S_RESPOND;
            end else begin
              state <= S_FREAD;
            end
          end
        end
        S_FREAD: begin
          state <= S_FCHECK;
        end
        S_FCHECK: begin
          if (bit_set) begin
            if (blocks_in_use != '0) begin
              blocks_in_use <= blocks_in_use - 1'b1;
            end
          end else begin
            res_status <= STATUS_REJECT;
          end
          state <= S_RESPOND;
        end
        S_RESPOND: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_addr   <= res_addr;
            rsp_count  <= blocks_in_use;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !ram_we)
    else $error("bitmap written during a scan");

  a_alloc_counts: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |=> blocks_in_use == $past(blocks_in_use) + 1'b1)
    else $error("allocate did not count the block");

  a_div_in_free: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside a free");

  a_rsp_from_respond: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_RESPOND)
    else $error("response loaded outside the respond state");

  a_free_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_FREAD |-> 32'(blk) < 32'(managed))
    else $error("free of a block beyond the managed count");
`endif

endmodule

// File: tb/tb_bitmap_block_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap block allocator testbench
// Drives allocate and free requests through the request channel and changes
// the base address and block count between phases while the block is idle.
// Each response beat is checked against its directed row's typed response
// or else the in-bench model of bitmap and used count. A directed table comes
// first, then random phases with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int unsigned MAX_BLOCKS    = 4096;
  localparam int unsigned BLOCK_BYTES   = 4096;
  localparam int unsigned PHASES        = 14;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 900;
  localparam logic [IDX_W-1:0] REG_UNUSED = 8'hFF;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  used_count;
  } alloc_rsp_t;

  typedef enum {ROW_ALLOC, ROW_FREE, ROW_BASE, ROW_COUNT, ROW_SPARE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] value;
    bit          typed;
    alloc_rsp_t  rsp;
  } stim_row_t;

  logic clk;
  logic rst;

  bba_req_if req_ch();
  bba_rsp_if rsp_ch();
  bba_cfg_if cfg_ch();

  bitmap_block_allocator #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  logic [MAX_BLOCKS-1:0] used_map;
  int unsigned           blocks_held;
  logic [ADDR_W-1:0]     cfg_base;
  logic [CNT_W-1:0]      cfg_count;

  alloc_rsp_t  pending_rsps[$];
  stim_row_t   directed_rows[$];
  int          error_count;
  int          burst_left;
  bit          no_gaps;
  bit          hold_request;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned span_blocks();
    return (cfg_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(cfg_count);
  endfunction

  // Updates the bitmap model for one request and returns its response.
  function automatic alloc_rsp_t predict_request(logic mode, logic [ADDR_W-1:0] addr);
    alloc_rsp_t        r;
    int unsigned       limit;
    int unsigned       blk;
    int unsigned       b;
    bit                found;
    logic [ADDR_W-1:0] offset;
    limit = span_blocks();
    r.status = STATUS_OK;
    r.block_address = '0;
    if (mode == MODE_ALLOC) begin
      found = 1'b0;
      blk = 0;
      if (blocks_held < limit) begin
        for (b = 0; b < limit && !found; b++) begin
          if (!used_map[b]) begin
            found = 1'b1;
            blk = b;
          end
        end
      end
      if (found) begin
        used_map[blk] = 1'b1;
        blocks_held++;
        r.block_address = cfg_base + ADDR_W'(blk * BLOCK_BYTES);
      end else begin
        r.status = STATUS_FULL;
      end
    end else if (addr < cfg_base) begin
      r.status = STATUS_REJECT;
    end else begin
      offset = addr - cfg_base;
      blk = offset / BLOCK_BYTES;
      if (blk >= limit || !used_map[blk]) begin
        r.status = STATUS_REJECT;
      end else begin
        used_map[blk] = 1'b0;
        if (blocks_held > 0) blocks_held--;
      end
    end
    r.used_count = blocks_held[CNT_W-1:0];
    return r;
  endfunction

  function automatic void add_req(row_kind_t kind, logic [31:0] value, bit typed,
                                  logic [STAT_W-1:0] status, logic [ADDR_W-1:0] addr,
                                  logic [CNT_W-1:0] used);
    stim_row_t row;
    row.kind = kind;
    row.value = value;
    row.typed = typed;
    row.rsp = '{status: status, block_address: addr, used_count: used};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(row_kind_t kind, logic [31:0] value);
    add_req(kind, value, 1'b0, STATUS_OK, '0, '0);
  endfunction

  task automatic issue_request(logic mode, logic [ADDR_W-1:0] addr, bit typed,
                               alloc_rsp_t typed_rsp);
    alloc_rsp_t r;
    req_ch.valid <= 1'b1;
    req_ch.mode <= mode;
    req_ch.free_address <= addr;
    do @(posedge clk); while (!req_ch.ready);
    r = predict_request(mode, addr);
    pending_rsps.push_back(typed ? typed_rsp : r);
  endtask

  task automatic pace_sender();
    int gap;
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 6);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [IDX_W-1:0] idx, logic [31:0] value);
    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_BASE_ADDRESS) cfg_base = value;
    else if (idx == REG_BLOCK_COUNT) cfg_count = value[CNT_W-1:0];
  endtask

  // Response side: checks every beat and stalls on a pattern of its own.
  initial begin
    alloc_rsp_t  want;
    int          stall_style;
    int          style_left;
    int unsigned hold_left;
    stall_style = 0;
    style_left = 0;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (pending_rsps.size() == 0) begin
          $error("response beat with no request outstanding");
          error_count++;
        end else begin
          want = pending_rsps.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
            error_count++;
          end
          if (rsp_ch.block_address !== want.block_address) begin
            $error("block_address: expected %h, actual %h", want.block_address,
                   rsp_ch.block_address);
            error_count++;
          end
          if (rsp_ch.used_count !== want.used_count) begin
            $error("used_count: expected %0d, actual %0d", want.used_count,
                   rsp_ch.used_count);
            error_count++;
          end
        end
      end
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          stall_style = $urandom_range(0, 2);
          style_left = $urandom_range(20, 300);
        end else begin
          style_left--;
        end
        case (stall_style)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    stim_row_t         row;
    alloc_rsp_t        none;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] new_base;
    logic [CNT_W-1:0]  new_count;
    logic              mode;
    int unsigned       limit;
    int unsigned       blk;
    int                items;
    int                alloc_pct;
    int                pick;
    int                tries;
    bit                found;

    used_map = '0;
    blocks_held = 0;
    cfg_base = '0;
    cfg_count = '0;
    error_count = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    hold_request = 1'b0;
    none = '0;

    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.mode <= MODE_ALLOC;
    req_ch.free_address <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    add_req(ROW_ALLOC, 32'h0, 1, STATUS_FULL, 32'h0, 13'd0);
    add_req(ROW_FREE, 32'h0, 1, STATUS_REJECT, 32'h0, 13'd0);
    add_req(ROW_FREE, 32'hFFFF_FFFF, 1, STATUS_REJECT, 32'h0, 13'd0);
    add_cfg(ROW_SPARE, 32'hFFFF_FFFF);
    add_cfg(ROW_BASE, 32'h0001_0000);
    add_cfg(ROW_COUNT, 32'd3);
    add_req(ROW_ALLOC, 32'h0, 1, STATUS_OK, 32'h0001_0000, 13'd1);
    add_req(ROW_ALLOC, 32'h0, 1, STATUS_OK, 32'h0001_1000, 13'd2);
    add_req(ROW_FREE, 32'h0001_1FFF, 1, STATUS_OK, 32'h0, 13'd1);
    add_req(ROW_FREE, 32'h0001_1000, 1, STATUS_REJECT, 32'h0, 13'd1);
    add_req(ROW_FREE, 32'h0000_FFFF, 1, STATUS_REJECT, 32'h0, 13'd1);
    add_req(ROW_FREE, 32'h0001_3000, 1, STATUS_REJECT, 32'h0, 13'd1);
    add_req(ROW_ALLOC, 32'h0, 0, STATUS_OK, 32'h0, 13'd0);
    add_req(ROW_ALLOC, 32'h0, 0, STATUS_OK, 32'h0, 13'd0);
    add_req(ROW_ALLOC, 32'h0, 1, STATUS_FULL, 32'h0, 13'd3);
    add_cfg(ROW_COUNT, 32'd1);
    add_req(ROW_ALLOC, 32'h0, 1, STATUS_FULL, 32'h0, 13'd3);
    add_req(ROW_FREE, 32'h0001_2000, 0, STATUS_OK, 32'h0, 13'd0);
    add_req(ROW_FREE, 32'h0001_0000, 0, STATUS_OK, 32'h0, 13'd0);
    add_req(ROW_ALLOC, 32'h0, 0, STATUS_OK, 32'h0, 13'd0);
    add_cfg(ROW_COUNT, 32'd8191);
    add_cfg(ROW_BASE, 32'hFFFF_F000);
    add_req(ROW_ALLOC, 32'h0, 0, STATUS_OK, 32'h0, 13'd0);
    add_req(ROW_ALLOC, 32'h0, 0, STATUS_OK, 32'h0, 13'd0);
    add_req(ROW_FREE, 32'h0000_2000, 0, STATUS_OK, 32'h0, 13'd0);
    add_req(ROW_FREE, 32'hFFFF_FFFF, 0, STATUS_OK, 32'h0, 13'd0);
    add_req(ROW_FREE, 32'hFFFF_F000, 1, STATUS_REJECT, 32'h0, 13'd3);
    add_cfg(ROW_BASE, 32'h0);
    add_cfg(ROW_COUNT, 32'd4096);
    add_req(ROW_FREE, 32'h0, 1, STATUS_REJECT, 32'h0, 13'd3);
    add_req(ROW_ALLOC, 32'h0, 1, STATUS_OK, 32'h0, 13'd4);
    add_req(ROW_FREE, 32'h0, 1, STATUS_OK, 32'h0, 13'd3);
    add_req(ROW_FREE, 32'hFFFF_FFFF, 1, STATUS_REJECT, 32'h0, 13'd3);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_ALLOC: begin
          issue_request(MODE_ALLOC, row.value, row.typed, row.rsp);
          pace_sender();
        end
        ROW_FREE: begin
          issue_request(MODE_FREE, row.value, row.typed, row.rsp);
          pace_sender();
        end
        ROW_BASE: write_register(REG_BASE_ADDRESS, row.value);
        ROW_COUNT: write_register(REG_BLOCK_COUNT, row.value);
        default: write_register(REG_UNUSED, row.value);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      new_base = $urandom() & 32'hFFFF_F000;
      if ($urandom_range(0, 4) == 0) new_base = $urandom();
      if ($urandom_range(0, 3) == 0) new_count = $urandom_range(0, 8191);
      else new_count = $urandom_range(1, 64);
      case (p)
        0: begin new_base = 32'h0; new_count = 13'd4096; end
        1: begin new_base = 32'hFFFF_F000; new_count = 13'd8191; end
        2: begin new_base = 32'hFFFF_FFFF; new_count = 13'd1; end
        3: begin new_base = 32'h0; new_count = 13'd0; end
        4: new_count = 13'd4095;
        5: new_count = 13'd32;
        6: new_count = 13'd33;
        default: ;
      endcase
      write_register(REG_BASE_ADDRESS, new_base);
      write_register(REG_BLOCK_COUNT, {19'd0, new_count});
      no_gaps = (p % 4 == 3);
      alloc_pct = $urandom_range(30, 75);
      items = $urandom_range(100, 180);
      for (int n = 0; n < items; n++) begin
        if (p == 4 && n == 40) hold_request = 1'b1;
        if (p == 6 && n == 50) drain_responses();
        limit = span_blocks();
        pick = $urandom_range(0, 99);
        mode = MODE_FREE;
        addr = $urandom();
        if (pick < alloc_pct) begin
          mode = MODE_ALLOC;
        end else if (pick < 88) begin
          // Aim at a block that is currently held, falling back to any block.
          found = 1'b0;
          blk = 0;
          for (tries = 0; tries < 8 && !found && limit > 0; tries++) begin
            blk = $urandom_range(0, limit - 1);
            found = used_map[blk];
          end
          addr = cfg_base + blk * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1);
        end else if (pick < 93) begin
          if (cfg_base != 0) addr = $urandom_range(0, cfg_base - 1);
        end else if (pick < 97) begin
          addr = cfg_base + (limit + $urandom_range(0, 100)) * BLOCK_BYTES
                 + $urandom_range(0, BLOCK_BYTES - 1);
        end else begin
          mode = 1'($urandom_range(0, 1));
        end
        issue_request(mode, addr, 1'b0, none);
        pace_sender();
      end
    end

    drain_responses();
    repeat (200) @(posedge clk);
    if (pending_rsps.size() != 0) begin
      $error("%0d responses never arrived", pending_rsps.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
